/* src/signed_int64_to_decimal_ascii_core_macros.svh */
// Assertion macros for the RTL.
`ifndef SIGNED_INT64_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT64_TO_DECIMAL_ASCII_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// a holds -> b holds in the same cycle
`define ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// a holds -> b holds in the next cycle
`define ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, a, b)
`define ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

/* src/s2d_pkg.sv */
package s2d_pkg;

    localparam int NumW      = 64;
    localparam int NumDigits = 20;
    localparam int BcdW      = 4 * NumDigits;
    localparam int DigCntW   = $clog2(NumDigits + 1);
    localparam int BitCntW   = $clog2(NumW);

    localparam logic [7:0] CharZero  = 8'd48;
    localparam logic [7:0] CharNine  = 8'd57;
    localparam logic [7:0] CharMinus = 8'd45;

    typedef struct packed {
        logic [BcdW-1:0] bcd;
        logic            negative;
    } s2d_conv_t;

endpackage

/* src/signed_int64_to_decimal_ascii_core.sv */
// Converts one signed 64-bit integer per item into its decimal ASCII text, most significant
// character first: '-' for negative values, then the digits with no leading zeros ('0' for
// zero); the most negative value prints as -9223372036854775808. is_last marks the final
// character. An item runs through the bit-serial binary-to-BCD shifter (one input bit
// per cycle), which then hands the BCD digits over; next a phase drops the leading
// zeros, then a minus sign, if any, and the digits are emitted into the output register,
// where each character waits while the output is stalled. One item is converted at a
// time; the next item is taken only after the last character is registered, once the
// done strobe has cleared the busy flag.
`include "signed_int64_to_decimal_ascii_core_macros.svh"

module signed_int64_to_decimal_ascii_core
    import s2d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   number_valid,
    output logic                   number_stall,
    input  logic signed [NumW-1:0] number_in,
    output logic                   text_valid,
    input  logic                   text_stall,
    output logic [7:0]             text_char,
    output logic                   is_last
);

    logic      busy_reg, busy_next;
    logic      accept;
    logic      conv_done;
    logic      emit_done;
    logic      char_ok;
    s2d_conv_t conv;

    assign accept       = number_valid && !busy_reg;
    assign number_stall = busy_reg;
    assign char_ok      = text_char == CharMinus
                          || (text_char >= CharZero && text_char <= CharNine);

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (emit_done)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    s2d_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .number (number_in),
        .done   (conv_done),
        .conv   (conv)
    );

    s2d_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (conv_done),
        .conv       (conv),
        .done       (emit_done),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_char  (text_char),
        .is_last    (is_last)
    );

    `ASSERT_NXT(a_busy_after_accept, clk, rst_n, number_valid && !number_stall, number_stall)
    `ASSERT_IMP(a_char_legal, clk, rst_n, text_valid, char_ok)
    `ASSERT_IMP(a_minus_not_last, clk, rst_n, text_valid && text_char == CharMinus, !is_last)
    `ASSERT_IMP(a_done_when_busy, clk, rst_n, emit_done || conv_done, busy_reg)

endmodule

/* src/s2d_dabble.sv */
module s2d_dabble
    import s2d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NumW-1:0] number,
    output logic            done,
    output s2d_conv_t       conv
);

    logic               running_reg, running_next;
    logic               done_reg, done_next;
    logic [BitCntW-1:0] cnt_reg, cnt_next;
    logic [NumW-1:0]    bin_reg, bin_next;
    logic [BcdW-1:0]    bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [BcdW-1:0]    bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NumDigits; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        if (start)
        begin
            running_next = 1'b1;
            cnt_next     = '1;
            neg_next     = number[NumW-1];
            bin_next     = number[NumW-1] ? (~number + 1'b1) : number;
            bcd_next     = '0;
        end
        else if (running_reg)
        begin
            bcd_next = {bcd_adj[BcdW-2:0], bin_reg[NumW-1]};
            bin_next = {bin_reg[NumW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign done          = done_reg;
    assign conv.bcd      = bcd_reg;
    assign conv.negative = neg_reg;

endmodule

/* src/s2d_emit.sv */
module s2d_emit
    import s2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  s2d_conv_t  conv,
    output logic       done,
    output logic       text_valid,
    input  logic       text_stall,
    output logic [7:0] text_char,
    output logic       is_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t             state_reg, state_next;
    logic [BcdW-1:0]    bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [DigCntW-1:0] cnt_reg, cnt_next;
    logic               valid_reg, valid_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;
    logic               done_reg, done_next;
    logic               out_free;
    logic [3:0]         top_digit;

    assign out_free  = !valid_reg || !text_stall;
    assign top_digit = bcd_reg[BcdW-1 -: 4];

    always_comb
    begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && text_stall;
        char_next  = char_reg;
        last_next  = last_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    bcd_next   = conv.bcd;
                    neg_next   = conv.negative;
                    cnt_next   = DigCntW'(NumDigits);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == 4'd0 && cnt_reg != DigCntW'(1))
                begin
                    bcd_next = {bcd_reg[BcdW-5:0], 4'd0};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                    state_next = neg_reg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    char_next  = CharMinus;
                    last_next  = 1'b0;
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    char_next  = CharZero + {4'd0, top_digit};
                    last_next  = (cnt_reg == DigCntW'(1));
                    bcd_next   = {bcd_reg[BcdW-5:0], 4'd0};
                    cnt_next   = cnt_reg - 1'b1;
                    if (cnt_reg == DigCntW'(1))
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            char_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            char_reg  <= char_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign done       = done_reg;
    assign text_valid = valid_reg;
    assign text_char  = char_reg;
    assign is_last    = last_reg;

endmodule

/* dv/decimal_text_checker.sv */
module decimal_text_checker
    import s2d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   number_valid,
    input  logic                   number_stall,
    input  logic signed [NumW-1:0] number_in,
    input  logic                   text_valid,
    input  logic                   text_stall,
    input  logic [7:0]             text_char,
    input  logic                   is_last,
    output int                     pending_chars,
    output int                     error_count
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_item_t;

    text_item_t expected_text[$];
    int         reported = 0;
    int         errors_q = 0;
    int         pending_q = 0;

    assign pending_chars = pending_q;
    assign error_count   = errors_q;

    function automatic void predict_text(input logic [NumW-1:0] raw);
        logic [NumW-1:0] mag;
        logic [NumW-1:0] rem;
        logic [7:0]      digits [NumDigits];
        int              n;
        text_item_t      item;
        mag = raw[NumW-1] ? (~raw + 1'b1) : raw;
        n = 0;
        do
        begin
            rem = mag % 64'd10;
            digits[n] = CharZero + rem[7:0];
            mag = mag / 64'd10;
            n++;
        end
        while (mag != 0 && n < NumDigits);
        if (raw[NumW-1])
        begin
            item.ch = CharMinus;
            item.last = 1'b0;
            expected_text.push_back(item);
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            item.ch = digits[k];
            item.last = (k == 0);
            expected_text.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        text_item_t got;
        text_item_t want;
        if (rst_n)
        begin
            if (number_valid && !number_stall)
                predict_text(number_in);
            if (text_valid && !text_stall)
            begin
                got.ch = text_char;
                got.last = is_last;
                if (expected_text.size() == 0)
                begin
                    errors_q++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("unexpected item: char %0d last %0d", got.ch, got.last);
                    end
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (got !== want)
                    begin
                        errors_q++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("mismatch: expected char %0d last %0d, got char %0d last %0d",
                                     want.ch, want.last, got.ch, got.last);
                        end
                    end
                end
            end
        end
        pending_q <= expected_text.size();
    end

endmodule

/* dv/tb_top.sv */
module tb_top;
    import s2d_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   number_valid;
    logic                   number_stall;
    logic signed [NumW-1:0] number_in;
    logic                   text_valid;
    logic                   text_stall;
    logic [7:0]             text_char;
    logic                   is_last;
    logic                   quiet;
    int                     pending_chars;
    int                     error_count;

    signed_int64_to_decimal_ascii_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_stall (number_stall),
        .number_in    (number_in),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_char    (text_char),
        .is_last      (is_last)
    );

    decimal_text_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .number_valid  (number_valid),
        .number_stall  (number_stall),
        .number_in     (number_in),
        .text_valid    (text_valid),
        .text_stall    (text_stall),
        .text_char     (text_char),
        .is_last       (is_last),
        .pending_chars (pending_chars),
        .error_count   (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
        text_stall <= !quiet && ($urandom_range(0, 99) < 31);

    function automatic logic [NumW-1:0] directed_number(input int idx);
        case (idx)
            0:       return 64'd0;
            1:       return 64'd1;
            2:       return 64'hFFFF_FFFF_FFFF_FFFF;
            3:       return 64'd9;
            4:       return 64'd10;
            5:       return -64'd9;
            6:       return -64'd10;
            7:       return 64'd99;
            8:       return 64'd100;
            9:       return -64'd12345;
            10:      return 64'h7FFF_FFFF_FFFF_FFFF;
            11:      return 64'h8000_0000_0000_0000;
            12:      return 64'h8000_0000_0000_0001;
            13:      return 64'd999999999999999999;
            14:      return 64'd1000000000000000000;
            15:      return -64'd1000000000000000000;
            16:      return 64'd1234567890123456789;
            17:      return 64'h5555_5555_5555_5555;
            default: return 64'hAAAA_AAAA_AAAA_AAAA;
        endcase
    endfunction

    function automatic logic [NumW-1:0] random_number();
        logic [NumW-1:0] v;
        logic [NumW-1:0] p;
        int              k;
        case ($urandom_range(0, 3))
            0:       v = {$urandom, $urandom};
            1:       v = {$urandom, $urandom} >> $urandom_range(44, 63);
            2:
            begin
                p = 64'd1;
                k = $urandom_range(0, 18);
                repeat (k) p = p * 64'd10;
                v = p + $urandom_range(0, 2) - 1;
            end
            default: v = {$urandom, $urandom} >> $urandom_range(1, 24);
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    task automatic send_number(input logic [NumW-1:0] value, input bit allow_gaps);
        while (allow_gaps && $urandom_range(0, 99) < 31)
        begin
            number_valid <= 1'b0;
            @(posedge clk);
        end
        number_valid <= 1'b1;
        number_in <= value;
        @(posedge clk);
        while (number_stall)
            @(posedge clk);
    endtask

    initial
    begin
        bit gaps;
        rst_n = 1'b0;
        number_valid = 1'b0;
        number_in = '0;
        quiet = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 19; i++)
            send_number(directed_number(i), 1'b1);
        for (int i = 0; i < 91; i++)
        begin
            gaps = !(i >= 30 && i < 65);
            quiet <= !gaps;
            send_number(random_number(), gaps);
        end
        number_valid <= 1'b0;
        quiet <= 1'b0;
        @(posedge clk);
        while (pending_chars != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/s2d_pkg.sv
src/s2d_dabble.sv
src/s2d_emit.sv
src/signed_int64_to_decimal_ascii_core.sv
dv/decimal_text_checker.sv
dv/tb_top.sv
